// ===== hw/rtl/ttb_pkg.sv =====
// Package with payload types and constants for the triangle tangent/binormal block.
package ttb_pkg;

    localparam int Q14_ONE = 16384;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [23:0] tex_u;
        logic signed [23:0] tex_v;
    } t_corner;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] binormal_x;
        logic signed [15:0] binormal_y;
        logic signed [15:0] binormal_z;
        logic               degenerate;
    } t_result;

    // Edge set for one triangle, handed from the front to the back end.
    typedef struct packed {
        logic signed [32:0] e1x;
        logic signed [32:0] e1y;
        logic signed [32:0] e1z;
        logic signed [32:0] e2x;
        logic signed [32:0] e2y;
        logic signed [32:0] e2z;
        logic signed [24:0] du1;
        logic signed [24:0] dv1;
        logic signed [24:0] du2;
        logic signed [24:0] dv2;
    } t_edges;

endpackage

// ===== hw/rtl/ttb_front.sv =====
// Front end: holds the first two corners and forms the edges on the third.
module ttb_front import ttb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_corner i_corner,
    output logic    o_full,
    output logic    o_valid,
    output t_edges  o_edges,
    input  logic    i_ready
);
    logic [1:0] r_count;
    t_corner    r_c0;
    t_corner    r_c1;
    logic       r_valid;
    t_edges     r_edges;
    logic       w_acc;

    assign o_full  = r_valid && !i_ready;
    assign w_acc   = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_edges = r_edges;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_acc && r_count == 2'd2) r_valid <= 1'b1;
            else if (r_valid && i_ready) r_valid <= 1'b0;
            if (w_acc) begin
                if (r_count == 2'd2) r_count <= 2'd0;
                else r_count <= r_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            if (r_count == 2'd0) r_c0 <= i_corner;
            if (r_count == 2'd1) r_c1 <= i_corner;
            if (r_count == 2'd2) begin
                r_edges.e1x <= 33'(r_c1.pos_x) - 33'(r_c0.pos_x);
                r_edges.e1y <= 33'(r_c1.pos_y) - 33'(r_c0.pos_y);
                r_edges.e1z <= 33'(r_c1.pos_z) - 33'(r_c0.pos_z);
                r_edges.e2x <= 33'(i_corner.pos_x) - 33'(r_c0.pos_x);
                r_edges.e2y <= 33'(i_corner.pos_y) - 33'(r_c0.pos_y);
                r_edges.e2z <= 33'(i_corner.pos_z) - 33'(r_c0.pos_z);
                r_edges.du1 <= 25'(r_c1.tex_u) - 25'(r_c0.tex_u);
                r_edges.dv1 <= 25'(r_c1.tex_v) - 25'(r_c0.tex_v);
                r_edges.du2 <= 25'(i_corner.tex_u) - 25'(r_c0.tex_u);
                r_edges.dv2 <= 25'(i_corner.tex_v) - 25'(r_c0.tex_v);
            end
        end
    end
endmodule

// ===== hw/rtl/ttb_fifo.sv =====
// Short queue of edge sets between the front and the back end.
module ttb_fifo import ttb_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_edges i_data,
    output logic   o_ready,
    output logic   o_valid,
    output t_edges o_data,
    input  logic   i_rd
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_edges           r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_wr && o_ready;
    assign w_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== hw/rtl/ttb_back.sv =====
// Back end: multi-cycle sequencer for determinant, directions and normalization.
module ttb_back import ttb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_edges  i_edges,
    output logic    o_take,
    output logic    o_empty,
    output t_result o_result,
    input  logic    i_pop
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_VEC  = 4'd2;
    localparam logic [3:0] S_ABS  = 4'd3;
    localparam logic [3:0] S_SHF  = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_SQRT = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]         r_state;
    t_edges             r_e;
    logic [2:0]         r_step;     // multiply step within S_MUL
    logic signed [58:0] r_p [8];    // products
    logic               r_vsel;     // 0 tangent, 1 binormal
    logic signed [59:0] r_n [3];
    logic [58:0]        r_m [3];
    logic [2:0]         r_neg;
    logic signed [50:0] r_det;
    logic [5:0]         r_cnt;
    logic [61:0]        r_sum;
    logic [61:0]        r_rem;
    logic [31:0]        r_root;
    logic [1:0]         r_k;
    logic [14:0]        r_q;
    logic [15:0]        r_out [6];
    logic               r_bad;
    logic               r_full;
    t_result            r_res;

    // One shared 33x25 signed multiplier.
    logic signed [32:0] w_ma;
    logic signed [24:0] w_mb;
    logic signed [57:0] w_mp;
    assign w_mp = w_ma * w_mb;

    always_comb begin
        w_ma = r_e.e1x;
        w_mb = r_e.dv2;
        case (r_step)
            3'd0: begin w_ma = 33'(r_e.du1); w_mb = r_e.dv2; end
            3'd1: begin w_ma = 33'(r_e.dv1); w_mb = r_e.du2; end
            3'd2: begin w_ma = r_vsel ? r_e.e2x : r_e.e1x; w_mb = r_vsel ? r_e.du1 : r_e.dv2; end
            3'd3: begin w_ma = r_vsel ? r_e.e1x : r_e.e2x; w_mb = r_vsel ? r_e.du2 : r_e.dv1; end
            3'd4: begin w_ma = r_vsel ? r_e.e2y : r_e.e1y; w_mb = r_vsel ? r_e.du1 : r_e.dv2; end
            3'd5: begin w_ma = r_vsel ? r_e.e1y : r_e.e2y; w_mb = r_vsel ? r_e.du2 : r_e.dv1; end
            3'd6: begin w_ma = r_vsel ? r_e.e2z : r_e.e1z; w_mb = r_vsel ? r_e.du1 : r_e.dv2; end
            default: begin
                w_ma = r_vsel ? r_e.e1z : r_e.e2z;
                w_mb = r_vsel ? r_e.du2 : r_e.dv1;
            end
        endcase
    end

    // Shift search: max magnitude reduced one bit per cycle below 2^30.
    logic [58:0] w_mx;
    assign w_mx = r_m[0] | r_m[1] | r_m[2];

    // Square of one shifted component, below 2^60.
    logic [29:0] w_sqa;
    logic [59:0] w_sq;
    assign w_sqa = r_m[r_k][29:0];
    assign w_sq  = w_sqa * w_sqa;

    // Restoring square root, one result bit per cycle.
    logic [61:0] w_trial;
    logic [63:0] w_rem2;
    assign w_rem2  = {r_rem, r_sum[61:60]};
    assign w_trial = {r_root[29:0], 2'b01};

    assign o_take   = (r_state == S_IDLE) && i_valid;
    assign o_empty  = !r_full;
    assign o_result = r_res;

    logic [15:0] w_qs;
    assign w_qs = r_neg[r_k] ? 16'(-{1'b0, r_q}) : {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_full  <= 1'b0;
        end else begin
            if (r_full && i_pop) r_full <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_e <= i_edges; r_step <= '0; r_vsel <= 1'b0;
                    r_bad <= 1'b0; r_state <= S_MUL;
                end
                S_MUL: begin
                    r_p[r_step] <= 59'(w_mp);
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) r_state <= S_VEC;
                end
                S_VEC: begin
                    if (!r_vsel) r_det <= 51'(r_p[0]) - 51'(r_p[1]);
                    r_n[0] <= 60'(r_p[2]) - 60'(r_p[3]);
                    r_n[1] <= 60'(r_p[4]) - 60'(r_p[5]);
                    r_n[2] <= 60'(r_p[6]) - 60'(r_p[7]);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    for (int k = 0; k < 3; k++) begin
                        r_m[k]   <= 59'(r_n[k][59] ? -r_n[k] : r_n[k]);
                        r_neg[k] <= r_n[k][59] ^ r_det[50];
                    end
                    if (r_det == '0) begin r_bad <= 1'b1; r_state <= S_DONE; end
                    else r_state <= S_SHF;
                end
                S_SHF: begin
                    if (w_mx == '0) begin r_bad <= 1'b1; r_state <= S_DONE; end
                    else if (w_mx[58:30] != '0) begin
                        for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 1;
                    end else begin
                        r_k <= 2'd0; r_sum <= '0; r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sum <= r_sum + 62'(w_sq);
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd2) begin
                        r_rem <= '0; r_root <= '0; r_cnt <= 6'd31; r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sum <= r_sum << 2;
                    if (w_rem2 >= {2'b00, w_trial}) begin
                        r_rem  <= 62'(w_rem2 - {2'b00, w_trial});
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= 62'(w_rem2);
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_k <= 2'd0; r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Setup on count 0, 46 shift-subtract steps, quotient stored on count 47.
                    if (r_cnt == 6'd0) begin
                        if (r_root == '0) begin r_bad <= 1'b1; r_state <= S_DONE; end
                        r_cnt <= 6'd1;
                    end else if (r_cnt == 6'd47) begin
                        r_out[{r_vsel, 1'b0} + {1'b0, r_vsel} + 3'(r_k)] <= w_qs;
                        r_cnt <= 6'd0;
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            if (r_vsel) r_state <= S_DONE;
                            else begin
                                r_vsel <= 1'b1; r_step <= 3'd2; r_state <= S_MUL;
                            end
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_DONE: if (!r_full) begin
                    if (r_bad) r_res <= t_result'(97'd1);
                    else r_res <= {r_out[0], r_out[1], r_out[2], r_out[3], r_out[4],
                                   r_out[5], 1'b0};
                    r_full <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Long division datapath kept separate: partial remainder and quotient.
    logic [45:0] r_dividend;
    logic [31:0] r_prem;
    logic [32:0] w_pr2;
    assign w_pr2 = {r_prem, r_dividend[45]};
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV) begin
            if (r_cnt == 6'd0) begin
                r_dividend <= 46'({r_m[r_k][29:0], 14'd0}) + 46'(r_root[31:1]);
                r_prem <= '0;
                r_q <= '0;
            end else if (r_cnt <= 6'd46) begin
                r_dividend <= r_dividend << 1;
                if (w_pr2 >= {1'b0, r_root}) begin
                    r_prem <= 32'(w_pr2 - {1'b0, r_root});
                    if (r_cnt >= 6'd32) r_q <= {r_q[13:0], 1'b1};
                end else begin
                    r_prem <= w_pr2[31:0];
                    if (r_cnt >= 6'd32) r_q <= {r_q[13:0], 1'b0};
                end
            end
        end
    end

    property p_take_idle;
        @(posedge i_clk) disable iff (!i_rst_n) o_take |=> (r_state == S_MUL);
    endproperty
    a_take_idle: assert property (p_take_idle) else $error("take outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && !i_pop) |=> (r_full && $stable(o_result))) else $error("result lost");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_full) |=> r_full) else $error("result not posted");
endmodule

// ===== hw/rtl/triangle_tangent_binormal.sv =====
// Top level of the triangle tangent/binormal block.
// channel  | ports                       | request moves when
// corner   | i_push, o_full, i_corner    | i_push && !o_full
// result   | o_empty, i_pop, o_result    | i_pop && !o_empty
// Corners are accepted one per cycle while the edge queue has room.
// A triangle occupies the back end for two 31-step square roots and six divisions,
// plus one shift search per vector.
// A degenerate triangle finishes early. A result held for pop stalls the back end; corners stall once the queue fills.
// Reset (synchronous, active low) clears the corner count and all queues.
// A two-entry edge queue lets corners keep arriving while the back end works.
module triangle_tangent_binormal import ttb_pkg::*; #(
    parameter int QDEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_full,
    input  t_corner i_corner,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);
    logic   w_fv, w_fr, w_qv, w_take;
    t_edges w_fe, w_qe;

    ttb_front u_front (.i_clk, .i_rst_n, .i_push, .i_corner, .o_full,
        .o_valid(w_fv), .o_edges(w_fe), .i_ready(w_fr));
    ttb_fifo #(.DEPTH(QDEPTH)) u_fifo (.i_clk, .i_rst_n, .i_wr(w_fv), .i_data(w_fe),
        .o_ready(w_fr), .o_valid(w_qv), .o_data(w_qe), .i_rd(w_take));
    ttb_back u_back (.i_clk, .i_rst_n, .i_valid(w_qv), .i_edges(w_qe), .o_take(w_take),
        .o_empty, .o_result, .i_pop);
endmodule

// ===== tb/triangle_tangent_binormal_tb.sv =====
// Self-checking testbench for the triangle tangent/binormal block.
`timescale 1ns / 1ps

module triangle_tangent_binormal_tb;
    import ttb_pkg::*;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_push = 1'b0;
    logic    i_pop = 1'b0;
    t_corner i_corner = '0;
    logic    o_full;
    logic    o_empty;
    t_result o_result;

    triangle_tangent_binormal dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_corner(i_corner), .o_empty(o_empty), .i_pop(i_pop), .o_result(o_result)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: corners held until the third arrives.
    int          corners_held;
    t_corner     held_corner [2];
    t_result     pending_results [$];
    int          mismatch_count = 0;
    bit          stimulus_done = 0;
    bit          calm = 0;

    // Directed table: corner plus optional typed-in expectation.
    typedef struct {
        t_corner c;
        bit      has_exp;
        t_result exp;
    } t_row;
    t_row directed_rows [$];

    function automatic logic [63:0] isqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Scales a vector to Q1.14; returns 0 when its length is zero.
    function automatic bit unit_vector(input longint n [3], input bit flip,
                                       output logic [15:0] q [3]);
        logic [63:0] m [3];
        logic [63:0] mx, total, len, v;
        bit          neg [3];
        int          s;
        mx = 0;
        total = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = (n[k] < 0) != flip;
            m[k] = (n[k] < 0) ? -n[k] : n[k];
            if (m[k] > mx) mx = m[k];
        end
        if (mx == 0) return 0;
        s = 0;
        while ((mx >> s) >= (64'd1 << 30)) s++;
        for (int k = 0; k < 3; k++) begin
            m[k] = m[k] >> s;
            total = total + m[k] * m[k];
        end
        len = isqrt(total);
        if (len == 0) return 0;
        for (int k = 0; k < 3; k++) begin
            v = (m[k] * Q14_ONE + (len >> 1)) / len;
            if (v > Q14_ONE) v = Q14_ONE;
            q[k] = neg[k] ? 16'(-v) : 16'(v);
        end
        return 1;
    endfunction

    function automatic t_result triangle_frame(t_corner c0, t_corner c1, t_corner c2);
        longint      e1 [3], e2 [3], tn [3], bn [3];
        longint      du1, dv1, du2, dv2, det;
        logic [15:0] tq [3], bq [3];
        bit          ok;
        t_result     r;
        e1[0] = longint'(c1.pos_x) - c0.pos_x;
        e1[1] = longint'(c1.pos_y) - c0.pos_y;
        e1[2] = longint'(c1.pos_z) - c0.pos_z;
        e2[0] = longint'(c2.pos_x) - c0.pos_x;
        e2[1] = longint'(c2.pos_y) - c0.pos_y;
        e2[2] = longint'(c2.pos_z) - c0.pos_z;
        du1 = longint'(c1.tex_u) - c0.tex_u;
        dv1 = longint'(c1.tex_v) - c0.tex_v;
        du2 = longint'(c2.tex_u) - c0.tex_u;
        dv2 = longint'(c2.tex_v) - c0.tex_v;
        det = du1 * dv2 - dv1 * du2;
        for (int k = 0; k < 3; k++) begin
            tn[k] = dv2 * e1[k] - dv1 * e2[k];
            bn[k] = du1 * e2[k] - du2 * e1[k];
        end
        ok = (det != 0);
        if (ok) ok = unit_vector(tn, det < 0, tq);
        if (ok) ok = unit_vector(bn, det < 0, bq);
        r = '0;
        if (ok) begin
            r.tangent_x = tq[0];
            r.tangent_y = tq[1];
            r.tangent_z = tq[2];
            r.binormal_x = bq[0];
            r.binormal_y = bq[1];
            r.binormal_z = bq[2];
        end
        r.degenerate = !ok;
        return r;
    endfunction

    // Called for each accepted corner; the typed-in value, if any, overrides.
    task automatic note_corner(t_corner c, bit has_exp, t_result exp);
        t_result r;
        if (corners_held < 2) begin
            held_corner[corners_held] = c;
            corners_held++;
        end else begin
            corners_held = 0;
            r = has_exp ? exp : triangle_frame(held_corner[0], held_corner[1], c);
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    function automatic t_corner rand_corner(int mode);
        t_corner c;
        c.pos_x = $urandom;
        c.pos_y = $urandom;
        c.pos_z = $urandom;
        c.tex_u = 24'($urandom);
        c.tex_v = 24'($urandom);
        if (mode == 1) begin
            // Small coordinates, the usual case for a mesh.
            c.pos_x = $signed($urandom_range(0, 2097151)) - 1048576;
            c.pos_y = $signed($urandom_range(0, 2097151)) - 1048576;
            c.pos_z = $signed($urandom_range(0, 2097151)) - 1048576;
            c.tex_u = 24'($signed($urandom_range(0, 131071)) - 65536);
            c.tex_v = 24'($signed($urandom_range(0, 131071)) - 65536);
        end else if (mode == 2) begin
            // Tiny values make zero determinants and lengths likely.
            c.pos_x = $signed($urandom_range(0, 4)) - 2;
            c.pos_y = $signed($urandom_range(0, 4)) - 2;
            c.pos_z = $signed($urandom_range(0, 4)) - 2;
            c.tex_u = 24'($signed($urandom_range(0, 2)) - 1);
            c.tex_v = 24'($signed($urandom_range(0, 2)) - 1);
        end
        return c;
    endfunction

    function automatic t_corner mk(int x, int y, int z, int u, int v);
        t_corner c;
        c.pos_x = x;
        c.pos_y = y;
        c.pos_z = z;
        c.tex_u = 24'(u);
        c.tex_v = 24'(v);
        return c;
    endfunction

    task automatic add_row(t_corner c, bit has_exp, t_result exp);
        t_row row;
        row.c = c;
        row.has_exp = has_exp;
        row.exp = exp;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic push_corner(t_corner c, bit has_exp, t_result exp);
        if (!calm) begin
            while ($urandom_range(0, 99) < 23) begin
                @(negedge i_clk);
                i_push <= 1'b0;
                @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        i_push <= 1'b1;
        i_corner <= c;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        note_corner(c, has_exp, exp);
    endtask

    // Result side: random pop with the same idle rate.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_pop <= 1'b0;
        else i_pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= 23);
    end

    always @(posedge i_clk) begin
        t_result exp;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: %p", o_result);
            end else begin
                exp = pending_results.pop_front();
                if (o_result !== exp) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected %p, got %p", exp, o_result);
                end
            end
        end
    end

    initial begin
        t_result none, zero_deg, up;
        t_corner hi, lo;
        int      mode, waited;
        none = '0;
        zero_deg = '0;
        zero_deg.degenerate = 1'b1;
        hi = mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 24'h7fffff, 24'h7fffff);
        lo = mk(32'h80000000, 32'h80000000, 32'h80000000, 24'h800000, 24'h800000);
        // Axis-aligned triangle: tangent along x, binormal along y.
        add_row(mk(0, 0, 0, 0, 0), 0, none);
        add_row(mk(65536, 0, 0, 65536, 0), 0, none);
        up = '0;
        up.tangent_x = 16'(Q14_ONE);
        up.binormal_y = 16'(Q14_ONE);
        add_row(mk(0, 65536, 0, 0, 65536), 1, up);
        // Mirrored texture flips the tangent sign through the determinant.
        add_row(mk(0, 0, 0, 0, 0), 0, none);
        add_row(mk(65536, 0, 0, -65536, 0), 0, none);
        up.tangent_x = 16'(-Q14_ONE);
        add_row(mk(0, 65536, 0, 0, 65536), 1, up);
        // Identical texture coordinates give a zero determinant.
        add_row(hi, 0, none);
        add_row(lo, 0, none);
        add_row(mk(5, 6, 7, 24'h7fffff, 24'h7fffff), 1, zero_deg);
        // Collinear positions give a zero tangent with a nonzero determinant.
        add_row(mk(0, 0, 0, 0, 0), 0, none);
        add_row(mk(0, 0, 0, 65536, 0), 0, none);
        add_row(mk(0, 0, 0, 0, 65536), 1, zero_deg);
        // Extreme positions and texture coordinates, predicted.
        add_row(hi, 0, none);
        add_row(lo, 0, none);
        add_row(mk(32'h80000000, 32'h7fffffff, 0, 24'h800000, 24'h7fffff), 0, none);
        add_row(lo, 0, none);
        add_row(hi, 0, none);
        add_row(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 24'h7fffff, 24'h800000),
                0, none);
        add_row(mk(0, 0, 0, 24'h800000, 0), 0, none);
        add_row(mk(32'h7fffffff, 0, 0, 24'h7fffff, 0), 0, none);
        add_row(mk(0, 32'h80000000, 32'h7fffffff, 0, 24'h7fffff), 0, none);

        corners_held = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i])
            push_corner(directed_rows[i].c, directed_rows[i].has_exp, directed_rows[i].exp);
        for (int i = 0; i < 1250; i++) begin
            calm = (i >= 500 && i < 700);
            mode = $urandom_range(0, 9);
            push_corner(rand_corner(mode < 5 ? 1 : (mode < 8 ? 2 : 0)), 0, none);
        end
        @(negedge i_clk);
        i_push <= 1'b0;
        calm = 0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (400) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Slowest run: about 424 triangles, under 2 ms.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
